// ===== hw/rtl/microwire_eeprom_master_macros.svh =====
`ifndef MICROWIRE_EEPROM_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define MWEM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define MWEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mwem_pkg.sv =====
`default_nettype none

package mwem_pkg;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// command codes
	localparam logic [2:0] OP_READ      = 3'd0;
	localparam logic [2:0] OP_WRITE     = 3'd1;
	localparam logic [2:0] OP_ERASE     = 3'd2;
	localparam logic [2:0] OP_WR_EN     = 3'd3;
	localparam logic [2:0] OP_WR_DIS    = 3'd4;
	localparam logic [2:0] OP_WRITE_ALL = 3'd5;
	localparam logic [2:0] OP_ERASE_ALL = 3'd6;

	// two-bit opcodes on the wire
	localparam logic [1:0] WIRE_READ  = 2'b10;
	localparam logic [1:0] WIRE_WRITE = 2'b01;
	localparam logic [1:0] WIRE_ERASE = 2'b11;
	localparam logic [1:0] WIRE_EXT   = 2'b00;

	// extended sub-op bits in word mode; byte mode uses them shifted left by one
	localparam logic [7:0] SUB_WR_EN     = 8'hc0;
	localparam logic [7:0] SUB_WRITE_ALL = 8'h40;
	localparam logic [7:0] SUB_ERASE_ALL = 8'h80;

	// bit counts
	localparam logic [4:0] FRAME_BITS = 5'd16;
	localparam logic [4:0] WORD_BITS  = 5'd16;
	localparam logic [4:0] BYTE_BITS  = 5'd8;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_FRAME = 6'b000010,
		PH_DATA  = 6'b000100,
		PH_RECV  = 6'b001000,
		PH_GAP   = 6'b010000,
		PH_WAIT  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        start_req;
		logic [2:0]  opcode;
		logic [8:0]  address;
		logic [15:0] write_data;
		logic        serial_in;
	} req_t;

	typedef struct packed {
		logic        chip_select;
		logic        serial_clock;
		logic        serial_out;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_value;
	} res_t;

	// command frame: start bit, wire opcode, address or sub-op bits
	function automatic logic [15:0] build_frame(input logic [2:0] op, input logic [8:0] addr,
			input logic word_org);
		logic [1:0]  wire_op;
		logic [7:0]  sub;
		logic [15:0] frame;
		wire_op = WIRE_EXT;
		sub     = '0;
		frame   = '0;
		case (op)
			OP_READ:      wire_op = WIRE_READ;
			OP_WRITE:     wire_op = WIRE_WRITE;
			OP_ERASE:     wire_op = WIRE_ERASE;
			OP_WR_EN:     sub = SUB_WR_EN;
			OP_WRITE_ALL: sub = SUB_WRITE_ALL;
			OP_ERASE_ALL: sub = SUB_ERASE_ALL;
			default:      sub = '0;
		endcase
		if (word_org) begin
			frame[10:8] = {1'b1, wire_op};
			frame[7:0]  = (op <= OP_ERASE) ? addr[7:0] : sub;
		end else begin
			frame[11:9] = {1'b1, wire_op};
			frame[8:0]  = (op <= OP_ERASE) ? addr : {sub, 1'b0};
		end
		return frame;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/microwire_eeprom_master.sv =====
// result: an accepted request's result is registered and shown in the output register in the next cycle
// throughput: one request per cycle unless req_stall holds it, each request is one tick of the pin sequence
// the output register frees itself in the cycle its result is taken, so no bubble
// reset: async active low, idle phase, shifters and counters zero, word_org set to 1
`default_nettype none

module microwire_eeprom_master
	import mwem_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_t               req,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output res_t                    res
);

	phase_t      phase_q, phase_n;
	logic [15:0] out_shift_q, out_shift_n;
	logic [15:0] in_shift_q, in_shift_n;
	logic [4:0]  bit_count_q, bit_count_n;
	logic        clock_high_q, clock_high_n;
	logic [2:0]  held_command_q, held_command_n;
	logic [15:0] held_data_q, held_data_n;
	logic        word_org_q;
	logic        res_valid_q;
	res_t        res_q, res_n;
	logic        accept;
	logic [4:0]  data_bits;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(PDATA_W-1){1'b0}}, word_org_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_org_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			word_org_q <= pwdata[0];
		end
	end

	// handshake
	assign req_stall = res_valid_q && res_stall;
	assign accept    = req_valid && !req_stall;
	assign data_bits = word_org_q ? WORD_BITS : BYTE_BITS;

	// one tick of the sequencer
	always_comb begin
		phase_n        = phase_q;
		out_shift_n    = out_shift_q;
		in_shift_n     = in_shift_q;
		bit_count_n    = bit_count_q;
		clock_high_n   = clock_high_q;
		held_command_n = held_command_q;
		held_data_n    = held_data_q;
		res_n          = '0;
		case (phase_q)
			PH_FRAME, PH_DATA: begin
				res_n.chip_select  = 1'b1;
				res_n.serial_clock = clock_high_q;
				res_n.serial_out   = out_shift_q[15];
				res_n.busy_res     = 1'b1;
				if (!clock_high_q) begin
					clock_high_n = 1'b1;
				end else begin
					clock_high_n = 1'b0;
					out_shift_n  = {out_shift_q[14:0], 1'b0};
					bit_count_n  = bit_count_q - 5'd1;
					if (bit_count_n == '0) begin
						if (phase_q == PH_DATA) begin
							phase_n = PH_GAP;
						end else if (held_command_q == OP_READ) begin
							phase_n     = PH_RECV;
							bit_count_n = data_bits;
						end else if (held_command_q == OP_WRITE ||
								held_command_q == OP_WRITE_ALL) begin
							phase_n     = PH_DATA;
							bit_count_n = data_bits;
							out_shift_n = word_org_q ? held_data_q : {held_data_q[7:0], 8'h00};
						end else if (held_command_q == OP_ERASE ||
								held_command_q == OP_ERASE_ALL) begin
							phase_n = PH_GAP;
						end else begin
							phase_n        = PH_IDLE;
							res_n.done_res = 1'b1;
						end
					end
				end
			end
			PH_RECV: begin
				res_n.chip_select  = 1'b1;
				res_n.serial_clock = clock_high_q;
				res_n.busy_res     = 1'b1;
				if (!clock_high_q) begin
					clock_high_n = 1'b1;
				end else begin
					clock_high_n = 1'b0;
					in_shift_n   = {in_shift_q[14:0], req.serial_in};
					bit_count_n  = bit_count_q - 5'd1;
					if (bit_count_n == '0) begin
						phase_n        = PH_IDLE;
						res_n.done_res = 1'b1;
					end
				end
			end
			PH_GAP: begin
				res_n.busy_res = 1'b1;
				phase_n        = PH_WAIT;
			end
			PH_WAIT: begin
				res_n.chip_select = 1'b1;
				res_n.busy_res    = 1'b1;
				if (req.serial_in) begin
					phase_n        = PH_IDLE;
					res_n.done_res = 1'b1;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (req.start_req && req.opcode <= OP_ERASE_ALL) begin
					held_command_n = req.opcode;
					held_data_n    = req.write_data;
					out_shift_n    = build_frame(req.opcode, req.address, word_org_q);
					bit_count_n    = FRAME_BITS;
					clock_high_n   = 1'b0;
					if (req.opcode == OP_READ) begin
						in_shift_n = '0;
					end
					phase_n = PH_FRAME;
				end
			end
		endcase
		res_n.read_value = in_shift_n;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			out_shift_q    <= '0;
			in_shift_q     <= '0;
			bit_count_q    <= '0;
			clock_high_q   <= 1'b0;
			held_command_q <= '0;
			held_data_q    <= '0;
		end else if (accept) begin
			phase_q        <= phase_n;
			out_shift_q    <= out_shift_n;
			in_shift_q     <= in_shift_n;
			bit_count_q    <= bit_count_n;
			clock_high_q   <= clock_high_n;
			held_command_q <= held_command_n;
			held_data_q    <= held_data_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mwem_checker.sv =====
`default_nettype none
`include "microwire_eeprom_master_macros.svh"

module mwem_checker
	import mwem_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire res_t res
);

	// a stalled result holds
	`MWEM_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

	// every accepted request shows a result on the next cycle
	`MWEM_ASSERT_NEXT(a_res_follows, req_valid && !req_stall, res_valid, "no result after request")

	// completion only while a command is active
	`MWEM_ASSERT_SAME(a_done_busy, res_valid && res.done_res, res.busy_res, "done without busy")

	// idle pins are quiet
	`MWEM_ASSERT_SAME(a_idle_pins, res_valid && !res.busy_res, !res.chip_select && !res.serial_clock && !res.serial_out, "pins active while idle")

endmodule

bind microwire_eeprom_master mwem_checker u_mwem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire

// ===== verif/mwem_pin_checker.sv =====
`timescale 1ns / 100ps

module mwem_pin_checker
	import mwem_pkg::*;
#(
	parameter logic [PADDR_W-1:0] WORD_ORG_ADDR = '0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire req_t               req,
	input  wire logic               res_valid,
	input  wire logic               res_stall,
	input  wire res_t               res,
	output int                      mismatches,
	output int                      pending
);

	// shadow of the master state
	phase_t      ph;
	logic [15:0] out_sr;
	logic [15:0] in_sr;
	logic [15:0] held_data;
	logic [4:0]  bits_left;
	logic        clk_hi;
	logic [2:0]  held_op;
	logic        org;

	// pin levels still owed by the block, oldest first
	res_t pin_levels_q[$];

	// start bit, wire opcode and address or sub-op bits
	function automatic logic [15:0] frame_for(input logic [2:0] op, input logic [8:0] addr,
			input logic word_mode);
		logic [1:0] code;
		logic [7:0] sub;
		logic [8:0] low;
		case (op)
			OP_READ:  code = WIRE_READ;
			OP_WRITE: code = WIRE_WRITE;
			OP_ERASE: code = WIRE_ERASE;
			default:  code = WIRE_EXT;
		endcase
		case (op)
			OP_WR_EN:     sub = SUB_WR_EN;
			OP_WRITE_ALL: sub = SUB_WRITE_ALL;
			OP_ERASE_ALL: sub = SUB_ERASE_ALL;
			default:      sub = 8'h00;
		endcase
		if (op <= OP_ERASE) begin
			low = word_mode ? {1'b0, addr[7:0]} : addr;
		end else begin
			low = word_mode ? {1'b0, sub} : {sub, 1'b0};
		end
		if (word_mode) begin
			return {5'b00000, 1'b1, code, low[7:0]};
		end
		return {4'b0000, 1'b1, code, low};
	endfunction

	// one tick: levels shown this tick, then the state advance
	function automatic res_t step_pins(input req_t r);
		res_t o;
		o = '0;
		case (ph)
			PH_FRAME, PH_DATA: begin
				o.chip_select  = 1'b1;
				o.serial_clock = clk_hi;
				o.serial_out   = out_sr[15];
				o.busy_res     = 1'b1;
			end
			PH_RECV: begin
				o.chip_select  = 1'b1;
				o.serial_clock = clk_hi;
				o.busy_res     = 1'b1;
			end
			PH_GAP: begin
				o.busy_res = 1'b1;
			end
			PH_WAIT: begin
				o.chip_select = 1'b1;
				o.busy_res    = 1'b1;
			end
			default: ;
		endcase

		case (ph)
			PH_FRAME, PH_DATA: begin
				if (!clk_hi) begin
					clk_hi = 1'b1;
				end else begin
					clk_hi    = 1'b0;
					out_sr    = out_sr << 1;
					bits_left = bits_left - 5'd1;
					if (bits_left == 5'd0) begin
						if (ph == PH_DATA) begin
							ph = PH_GAP;
						end else begin
							case (held_op)
								OP_READ: begin
									ph        = PH_RECV;
									bits_left = org ? WORD_BITS : BYTE_BITS;
								end
								OP_WRITE, OP_WRITE_ALL: begin
									ph        = PH_DATA;
									bits_left = org ? WORD_BITS : BYTE_BITS;
									out_sr    = org ? held_data : {held_data[7:0], 8'h00};
								end
								OP_ERASE, OP_ERASE_ALL: begin
									ph = PH_GAP;
								end
								default: begin
									ph         = PH_IDLE;
									o.done_res = 1'b1;
								end
							endcase
						end
					end
				end
			end
			PH_RECV: begin
				if (!clk_hi) begin
					clk_hi = 1'b1;
				end else begin
					clk_hi    = 1'b0;
					in_sr     = {in_sr[14:0], r.serial_in};
					bits_left = bits_left - 5'd1;
					if (bits_left == 5'd0) begin
						ph         = PH_IDLE;
						o.done_res = 1'b1;
					end
				end
			end
			PH_GAP: begin
				ph = PH_WAIT;
			end
			PH_WAIT: begin
				if (r.serial_in) begin
					ph         = PH_IDLE;
					o.done_res = 1'b1;
				end
			end
			default: begin
				ph = PH_IDLE;
				// a start with a known opcode latches the command
				if (r.start_req && r.opcode <= OP_ERASE_ALL) begin
					held_op   = r.opcode;
					held_data = r.write_data;
					out_sr    = frame_for(r.opcode, r.address, org);
					bits_left = FRAME_BITS;
					clk_hi    = 1'b0;
					if (r.opcode == OP_READ) begin
						in_sr = '0;
					end
					ph = PH_FRAME;
				end
			end
		endcase
		o.read_value = in_sr;
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] mismatch on %s: got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// watch the config port and both channels
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			ph         = PH_IDLE;
			out_sr     = '0;
			in_sr      = '0;
			held_data  = '0;
			bits_left  = '0;
			clk_hi     = 1'b0;
			held_op    = '0;
			org        = 1'b1;
			mismatches = 0;
			pending    = 0;
			pin_levels_q.delete();
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr == WORD_ORG_ADDR) begin
				org = pwdata[0];
			end

			// accepted result against the oldest prediction
			if (res_valid && !res_stall) begin
				if (pin_levels_q.size() == 0) begin
					flag_mismatch("result with no request", res.read_value, 16'h0000);
				end else begin
					want = pin_levels_q.pop_front();
					if (res.chip_select !== want.chip_select)
						flag_mismatch("chip_select", 16'(res.chip_select),
							16'(want.chip_select));
					if (res.serial_clock !== want.serial_clock)
						flag_mismatch("serial_clock", 16'(res.serial_clock),
							16'(want.serial_clock));
					if (res.serial_out !== want.serial_out)
						flag_mismatch("serial_out", 16'(res.serial_out),
							16'(want.serial_out));
					if (res.busy_res !== want.busy_res)
						flag_mismatch("busy_res", 16'(res.busy_res), 16'(want.busy_res));
					if (res.done_res !== want.done_res)
						flag_mismatch("done_res", 16'(res.done_res), 16'(want.done_res));
					if (res.read_value !== want.read_value)
						flag_mismatch("read_value", res.read_value, want.read_value);
				end
			end

			// accepted request
			if (req_valid && !req_stall) begin
				pin_levels_q.push_back(step_pins(req));
			end
			pending = pin_levels_q.size();
		end
	end

endmodule

// ===== verif/microwire_eeprom_master_tb.sv =====
`timescale 1ns / 100ps

module microwire_eeprom_master_tb;
	import mwem_pkg::*;

	localparam logic [PADDR_W-1:0] WORD_ORG_ADDR = '0;
	localparam logic [2:0]         OP_UNUSED     = 3'd7;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 60;
	localparam int HOLD_AT       = 200;
	localparam int RANDOM_TICKS  = 133;
	localparam int CMD_TICKS     = 75;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	res_t               res;

	int mismatches;
	int pending;
	int cycles = 0;
	int sent = 0;
	int taken = 0;
	logic send_calm = 1'b0;
	logic take_calm = 1'b0;

	always #6 clk = ~clk;

	microwire_eeprom_master u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	mwem_pin_checker #(
		.WORD_ORG_ADDR (WORD_ORG_ADDR)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one request after a random gap, hold it until taken
	task automatic send_tick(input req_t item);
		int gap;
		if (sent % 50 == 0) begin
			send_calm = ($urandom_range(0, 2) == 0);
		end
		gap = send_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!(req_valid && !req_stall));
		sent++;
	endtask

	// stop offering and let every owed result come out
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_word_org(input logic value);
		drain();
		apb_write(WORD_ORG_ADDR, {{(PDATA_W-1){1'b0}}, value});
	endtask

	// one command request followed by plain ticks and one more start, which the block ignores if still busy
	task automatic run_command(input logic [2:0] op, input logic [8:0] addr,
			input logic [15:0] data);
		req_t t;
		t.start_req  = 1'b1;
		t.opcode     = op;
		t.address    = addr;
		t.write_data = data;
		t.serial_in  = 1'b0;
		send_tick(t);
		for (int i = 0; i < CMD_TICKS; i++) begin
			t.start_req = (i == 5);
			t.opcode    = 3'($urandom_range(0, 6));
			t.address   = 9'($urandom);
			t.serial_in = (op == OP_READ) ? 1'($urandom_range(0, 1)) : (i >= CMD_TICKS - 5);
			send_tick(t);
		end
	endtask

	task automatic run_directed();
		run_command(OP_READ, 9'h1ff, 16'h0000);
		run_command(OP_WRITE, 9'h000, 16'hffff);
		run_command(OP_ERASE, 9'h1ff, 16'h0000);
		run_command(OP_WR_EN, 9'h000, 16'h0000);
		run_command(OP_WR_DIS, 9'h1ff, 16'hffff);
		run_command(OP_WRITE_ALL, 9'h1ff, 16'h0000);
		run_command(OP_ERASE_ALL, 9'h000, 16'hffff);
		run_command(OP_UNUSED, 9'h1ff, 16'hffff);
		run_command(OP_READ, 9'h000, 16'hffff);
	endtask

	// random ticks, ready line density changes every segment
	task automatic run_random(input int n);
		req_t t;
		int   sin_pct;
		sin_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       sin_pct = 50;
					1:       sin_pct = 12;
					default: sin_pct = 3;
				endcase
			end
			t.start_req  = ($urandom_range(0, 99) < 25);
			t.opcode     = 3'($urandom_range(0, 7));
			t.address    = 9'($urandom);
			t.write_data = 16'($urandom);
			t.serial_in  = ($urandom_range(0, 99) < sin_pct);
			send_tick(t);
		end
	endtask

	// result side: random hold-off per result, one long hold to back up the block
	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 40 == 0) begin
				take_calm = ($urandom_range(0, 2) == 0);
			end
			gap = take_calm ? 0 : $urandom_range(0, 8);
			if (taken == HOLD_AT) begin
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall));
			taken++;
		end
	end

	// stimulus and verdict
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		set_word_org(1'b0);
		run_directed();

		set_word_org(1'b1);
		run_random(RANDOM_TICKS);
		set_word_org(1'b0);
		run_random(RANDOM_TICKS);
		set_word_org(1'($urandom_range(0, 1)));
		run_random(RANDOM_TICKS);
		set_word_org(1'($urandom_range(0, 1)));
		run_random(RANDOM_TICKS);

		drain();
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
